// ===== hdl/bfu_pkg.sv =====
// ----------------------------------------------------------------------------
// bfu_pkg
// shared types, codes and helper functions of the bit field unpacker
// ----------------------------------------------------------------------------
package bfu_pkg;

    localparam int BUF_BITS   = 32;
    localparam int BYTE_BITS  = 8;
    localparam int FIELD_BITS = 24;
    localparam int HELD_W     = 6;
    localparam int WANT_W     = 5;

    // request codes
    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_GET  = 2'd1;
    localparam logic [1:0] REQ_PEEK = 2'd2;
    localparam logic [1:0] REQ_DROP = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_BUSY = 2'd2;

    // bit order codes
    localparam logic [1:0] ORDER_LSB     = 2'd0;
    localparam logic [1:0] ORDER_LSB_REV = 2'd1;
    localparam logic [1:0] ORDER_MSB     = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [7:0]        data_byte;
        logic [WANT_W-1:0] want_bits;
    } t_item;

    typedef struct packed {
        logic [BUF_BITS-1:0] bits;
        logic [HELD_W-1:0]   held;
        logic                pend_valid;
        logic [1:0]          pend_kind;
        logic [WANT_W-1:0]   pend_bits;
    } t_state;

    typedef struct packed {
        logic                  valid;
        logic [FIELD_BITS-1:0] field;
        logic [1:0]            status;
    } t_result;

    // ones in the low n bits, n up to 32
    function automatic logic [BUF_BITS-1:0] low_mask(input logic [HELD_W-1:0] n);
        return ~({BUF_BITS{1'b1}} << n);
    endfunction

    // low n bits of v in reversed order
    function automatic logic [BUF_BITS-1:0] rev_field(input logic [BUF_BITS-1:0] v,
                                                      input logic [HELD_W-1:0]   n);
        logic [BUF_BITS-1:0] r;
        for (int i = 0; i < BUF_BITS; i++) begin
            r[i] = v[BUF_BITS-1-i];
        end
        return r >> (HELD_W'(BUF_BITS) - n);
    endfunction

endpackage

// ===== hdl/bfu_exec.sv =====
// ----------------------------------------------------------------------------
// bfu_exec
// single-pass execution of one item against the bit buffer state
// ----------------------------------------------------------------------------
module bfu_exec
    import bfu_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 24
) (
    input  t_item      i_item,
    input  t_state     i_state,
    input  logic [1:0] i_bit_order,
    output t_state     o_state,
    output t_result    o_result
);

    localparam logic [WANT_W-1:0] MaxWant = WANT_W'(MAX_FIELD_BITS);

    logic [WANT_W-1:0]   want_sat;
    logic                is_push;
    logic                msb;
    logic [BUF_BITS-1:0] push_bits;
    logic [HELD_W-1:0]   push_held;
    logic [BUF_BITS-1:0] p_bits;
    logic [HELD_W-1:0]   p_held;
    logic [1:0]          p_kind;
    logic [HELD_W-1:0]   p_n;
    logic [HELD_W-1:0]   rem;
    logic [BUF_BITS-1:0] mask;
    logic [BUF_BITS-1:0] x;
    logic [BUF_BITS-1:0] post_bits;
    logic [FIELD_BITS-1:0] p_field;

    always_comb begin
        want_sat = (i_item.want_bits > MaxWant) ? MaxWant : i_item.want_bits;
        is_push  = (i_item.req_type == REQ_PUSH);
        msb      = (i_bit_order >= ORDER_MSB);

        // byte insertion, only valid when held <= 24
        if (msb) begin
            push_bits = {i_state.bits[BUF_BITS-BYTE_BITS-1:0], i_item.data_byte};
        end else begin
            push_bits = i_state.bits
                      | ({{(BUF_BITS-BYTE_BITS){1'b0}}, i_item.data_byte} << i_state.held);
        end
        push_held = i_state.held + HELD_W'(BYTE_BITS);

        // operands of the extraction: pending request after a push, or the new request
        p_bits = is_push ? push_bits : i_state.bits;
        p_held = is_push ? push_held : i_state.held;
        p_kind = is_push ? i_state.pend_kind : i_item.req_type;
        p_n    = HELD_W'(is_push ? i_state.pend_bits : want_sat);

        rem  = p_held - p_n;
        mask = low_mask(p_n);
        if (msb) begin
            x         = (p_bits >> rem) & mask;
            post_bits = p_bits & low_mask(rem);
        end else begin
            x         = p_bits & mask;
            if (i_bit_order == ORDER_LSB_REV) begin
                x = rev_field(x, p_n);
            end
            post_bits = p_bits >> p_n;
        end
        p_field = (p_kind == REQ_DROP) ? '0 : x[FIELD_BITS-1:0];

        o_state  = i_state;
        o_result = '0;

        if (is_push) begin
            if (i_state.held > HELD_W'(BUF_BITS - BYTE_BITS)) begin
                o_result.valid  = 1'b1;
                o_result.status = STATUS_FULL;
            end else begin
                o_state.bits = push_bits;
                o_state.held = push_held;
                if (i_state.pend_valid && push_held >= HELD_W'(i_state.pend_bits)) begin
                    o_state.pend_valid = 1'b0;
                    if (p_kind != REQ_PEEK) begin
                        o_state.bits = post_bits;
                        o_state.held = rem;
                    end
                    o_result.valid  = 1'b1;
                    o_result.field  = p_field;
                    o_result.status = STATUS_OK;
                end
            end
        end else if (i_state.pend_valid) begin
            o_result.valid  = 1'b1;
            o_result.status = STATUS_BUSY;
        end else if (i_state.held >= HELD_W'(want_sat)) begin
            if (p_kind != REQ_PEEK) begin
                o_state.bits = post_bits;
                o_state.held = rem;
            end
            o_result.valid  = 1'b1;
            o_result.field  = p_field;
            o_result.status = STATUS_OK;
        end else begin
            o_state.pend_valid = 1'b1;
            o_state.pend_kind  = i_item.req_type;
            o_state.pend_bits  = want_sat;
        end
    end

endmodule

// ===== hdl/bit_field_unpacker.sv =====
// ----------------------------------------------------------------------------
// bit_field_unpacker
// bitstream reader: byte push, field get / peek / drop over a 32-bit buffer
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled: a byte
// push or a get, peek or drop of 0 to MAX_FIELD_BITS bits (longer requests
// saturate). An accepted item is held in an input stage register, the bit
// buffer logic works on it in a single pass and the result item, if any,
// lands in an output register when the stage moves on; the result is
// offered from that register. The sustained rate is one item per cycle
// while the output is not stalled, set by the bit buffer update, which
// completes in that same pass so the next item sees the new state.
// A stalled output holds the stage; items that give no result (a push, or
// a request that must wait for bytes) pass through while the output is free.
// A request that needs more bits than are held is parked and its result comes
// with the push that supplies enough bits; a push to a full buffer gives
// status full, a request while one is parked gives status busy.
// bit_order: 0 LSB-first, 1 LSB-first with reversed fields, 2 or 3 MSB-first;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module bit_field_unpacker
    import bfu_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic [4:0]  i_want_bits,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_field_value,
    output logic [1:0]  o_status
);

    // input stage
    logic    r_stg_valid;
    t_item   r_stg;
    // bit buffer state and order register
    t_state  r_state;
    t_state  n_state;
    logic [1:0] r_bit_order;
    // output register
    logic    r_out_valid;
    t_result res;
    logic [FIELD_BITS-1:0] r_out_field;
    logic [1:0]            r_out_status;

    logic stg_go;
    logic in_take;

    // stage moves on whenever the output register can take a result
    assign stg_go     = r_stg_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_stg_valid || stg_go;
    assign in_take    = i_in_valid && o_in_ready;

    bfu_exec #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS)
    ) u_exec (
        .i_item      (r_stg),
        .i_state     (r_state),
        .i_bit_order (r_bit_order),
        .o_state     (n_state),
        .o_result    (res)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_order <= ORDER_LSB;
        end else if (i_cfg_we) begin
            r_bit_order <= i_cfg_data;
        end
    end

    // input stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_stg_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_stg.req_type  <= i_req_type;
            r_stg.data_byte <= i_data_byte;
            r_stg.want_bits <= i_want_bits;
        end
    end

    // buffer state advances with each executed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (stg_go) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stg_go && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_go && res.valid) begin
            r_out_field  <= res.field;
            r_out_status <= res.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_field_value = r_out_field;
    assign o_status      = r_out_status;

    // held count never goes past the buffer size
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.held <= HELD_W'(BUF_BITS))
        else $error("held bit count out of range");

    // a parked request always lacks bits
    a_pend_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pend_valid |-> (r_state.held < HELD_W'(r_state.pend_bits)))
        else $error("parked request has enough bits");

    // buffer bits above the held count stay clear
    a_buf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.bits & ~low_mask(r_state.held)) == '0)
        else $error("stale bits above held count");

    // a result only leaves the stage when the output register was free
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !stg_go)
        else $error("stage advanced into a stalled output");

endmodule
